### hw/rtl/qte_pkg.sv
package qte_pkg;

  localparam int unsigned IN_W      = 16;
  localparam int unsigned PROD_FRAC = 28;
  localparam int unsigned PROD_W    = 34;
  localparam int unsigned ANG_FRAC  = 30;
  localparam int unsigned ANG_W     = 34;
  localparam int unsigned OUT_FRAC  = 12;
  localparam int unsigned OUT_W     = 15;
  localparam int unsigned PITCH_W   = 14;
  localparam int unsigned ISQ_N     = 29;
  localparam int unsigned RAD_W     = 2 * ISQ_N;
  localparam int unsigned REM_W     = 34;
  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned MAX_STAGES = 24;

  localparam int unsigned LANE_ROLL  = 0;
  localparam int unsigned LANE_PITCH = 1;
  localparam int unsigned LANE_YAW   = 2;

  localparam logic signed [PROD_W-1:0] PROD_ONE = PROD_W'(64'd1 << PROD_FRAC);
  localparam logic signed [ANG_W-1:0] HALF_PI_ANG = ANG_W'(64'd1686629713);
  localparam logic signed [PITCH_W-1:0] HALF_PI_OUT = PITCH_W'(6434);

  localparam logic signed [ANG_W-1:0] ATAN_TAB [MAX_STAGES] = '{
    ANG_W'(64'd843314856), ANG_W'(64'd497837829), ANG_W'(64'd263043836),
    ANG_W'(64'd133525158), ANG_W'(64'd67021686),  ANG_W'(64'd33543515),
    ANG_W'(64'd16775850),  ANG_W'(64'd8388437),   ANG_W'(64'd4194282),
    ANG_W'(64'd2097149),   ANG_W'(64'd1048575),   ANG_W'(64'd524287),
    ANG_W'(64'd262143),    ANG_W'(64'd131071),    ANG_W'(64'd65535),
    ANG_W'(64'd32767),     ANG_W'(64'd16383),     ANG_W'(64'd8191),
    ANG_W'(64'd4095),      ANG_W'(64'd2047),      ANG_W'(64'd1023),
    ANG_W'(64'd511),       ANG_W'(64'd255),       ANG_W'(64'd127)
  };

  typedef struct packed {
    logic signed [PROD_W-1:0] roll_y;
    logic signed [PROD_W-1:0] roll_x;
    logic signed [PROD_W-1:0] yaw_y;
    logic signed [PROD_W-1:0] yaw_x;
    logic signed [PROD_W-1:0] s;
    logic                     sat_pos;
    logic                     sat_neg;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [RAD_W-1:0] rad;
  } front_t;

endpackage

### hw/rtl/qte_if.sv
interface qte_in_if;
  import qte_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] quat_w;
  logic signed [IN_W-1:0] quat_x;
  logic signed [IN_W-1:0] quat_y;
  logic signed [IN_W-1:0] quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_out_if;
  import qte_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [OUT_W-1:0]   roll_angle;
  logic signed [PITCH_W-1:0] pitch_angle;
  logic signed [OUT_W-1:0]   yaw_angle;

  modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

### hw/rtl/qte_front.sv
module qte_front import qte_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [IN_W-1:0] quat_w_i,
  input  logic signed [IN_W-1:0] quat_x_i,
  input  logic signed [IN_W-1:0] quat_y_i,
  input  logic signed [IN_W-1:0] quat_z_i,
  output logic                   valid_o,
  output front_t                 front_o
);

  logic [2:0] v_q;
  logic signed [2*IN_W-1:0] wx_q, yz_q, xx_q, yy_q, wz_q, xy_q, zz_q, wy_q, xz_q;
  side_t  side_q;
  front_t front_q;
  side_t  side_d;
  front_t front_d;
  logic signed [ISQ_N-1:0]   s_lo;
  logic signed [RAD_W-1:0]   s_sq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wx_q <= quat_w_i * quat_x_i;
      yz_q <= quat_y_i * quat_z_i;
      xx_q <= quat_x_i * quat_x_i;
      yy_q <= quat_y_i * quat_y_i;
      wz_q <= quat_w_i * quat_z_i;
      xy_q <= quat_x_i * quat_y_i;
      zz_q <= quat_z_i * quat_z_i;
      wy_q <= quat_w_i * quat_y_i;
      xz_q <= quat_x_i * quat_z_i;
    end
  end

  always_comb begin
    side_d.roll_y  = (PROD_W'(wx_q) + PROD_W'(yz_q)) <<< 1;
    side_d.roll_x  = PROD_ONE - ((PROD_W'(xx_q) + PROD_W'(yy_q)) <<< 1);
    side_d.yaw_y   = (PROD_W'(wz_q) + PROD_W'(xy_q)) <<< 1;
    side_d.yaw_x   = PROD_ONE - ((PROD_W'(yy_q) + PROD_W'(zz_q)) <<< 1);
    side_d.s       = (PROD_W'(wy_q) - PROD_W'(xz_q)) <<< 1;
    side_d.sat_pos = 1'b0;
    side_d.sat_neg = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_d;
    end
  end

  // Outside the open interval the radicand is never used.
  always_comb begin
    s_lo                 = side_q.s[ISQ_N-1:0];
    s_sq                 = s_lo * s_lo;
    front_d.side         = side_q;
    front_d.side.sat_pos = (side_q.s >= PROD_ONE);
    front_d.side.sat_neg = (side_q.s <= -PROD_ONE);
    front_d.rad          = (RAD_W'(1) << (2 * PROD_FRAC)) - RAD_W'(s_sq);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      front_q <= front_d;
    end
  end

  assign valid_o = v_q[2];
  assign front_o = front_q;

endmodule

### hw/rtl/qte_isqrt.sv
module qte_isqrt import qte_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [RAD_W-1:0] rad_i,
  output logic             valid_o,
  output logic [ISQ_N-1:0] root_o
);

  logic [ISQ_N-1:0] v_q;
  logic [RAD_W-1:0] rad_q  [ISQ_N];
  logic [REM_W-1:0] rem_q  [ISQ_N];
  logic [ISQ_N-1:0] root_q [ISQ_N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[ISQ_N-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < ISQ_N; k++) begin : g_step
    logic [RAD_W-1:0] rad_p;
    logic [REM_W-1:0] rem_p, rem_n, trial;
    logic [ISQ_N-1:0] root_p;
    logic [RAD_W-1:0] rad_d;
    logic [REM_W-1:0] rem_d;
    logic [ISQ_N-1:0] root_d;

    if (k == 0) begin : g_first
      assign rad_p  = rad_i;
      assign rem_p  = '0;
      assign root_p = '0;
    end else begin : g_next
      assign rad_p  = rad_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
    end

    always_comb begin
      rem_n = {rem_p[REM_W-3:0], rad_p[RAD_W-1 -: 2]};
      trial = REM_W'({root_p, 2'b01});
      rad_d = rad_p << 2;
      if (rem_n >= trial) begin
        rem_d  = rem_n - trial;
        root_d = {root_p[ISQ_N-2:0], 1'b1};
      end else begin
        rem_d  = rem_n;
        root_d = {root_p[ISQ_N-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_d;
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
      end
    end
  end

  assign valid_o = v_q[ISQ_N-1];
  assign root_o  = root_q[ISQ_N-1];

endmodule

### hw/rtl/qte_cordic.sv
module qte_cordic import qte_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16,
  parameter int unsigned FRAC_BITS     = 14
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [1:0]               side_i,
  input  logic signed [PROD_W-1:0] y_i [NUM_LANES],
  input  logic signed [PROD_W-1:0] x_i [NUM_LANES],
  output logic                     valid_o,
  output logic [1:0]               side_o,
  output logic signed [OUT_W-1:0]  ang_o [NUM_LANES]
);

  localparam int unsigned WW    = FRAC_BITS + 9;
  localparam int unsigned NST   = CORDIC_STAGES + 3;
  localparam int unsigned RND_K = (FRAC_BITS < PROD_FRAC) ? PROD_FRAC - FRAC_BITS : 1;
  localparam int unsigned ANG_K = ANG_FRAC - OUT_FRAC;

  logic [NST-1:0] v_q;
  logic [1:0]     sd_q [NST];

  logic signed [WW-1:0]    x0_q [NUM_LANES];
  logic signed [WW-1:0]    y0_q [NUM_LANES];
  logic signed [WW-1:0]    xs_q [CORDIC_STAGES+1][NUM_LANES];
  logic signed [WW-1:0]    ys_q [CORDIC_STAGES+1][NUM_LANES];
  logic signed [ANG_W-1:0] zs_q [CORDIC_STAGES+1][NUM_LANES];
  logic                    zr_q [CORDIC_STAGES+1][NUM_LANES];
  logic signed [OUT_W-1:0] ang_q [NUM_LANES];

  function automatic logic signed [WW-1:0] rnd_work(input logic signed [PROD_W-1:0] v);
    logic [PROD_W:0] ve;
    logic [PROD_W:0] mag;
    ve  = {v[PROD_W-1], v};
    mag = v[PROD_W-1] ? (~ve + 1'b1) : ve;
    mag = (mag + ((PROD_W+1)'(1) << (RND_K - 1))) >> RND_K;
    rnd_work = v[PROD_W-1] ? -$signed(WW'(mag)) : $signed(WW'(mag));
  endfunction

  function automatic logic signed [OUT_W-1:0] rnd_ang(input logic signed [ANG_W-1:0] z);
    logic [ANG_W:0] ze;
    logic [ANG_W:0] mag;
    ze  = {z[ANG_W-1], z};
    mag = z[ANG_W-1] ? (~ze + 1'b1) : ze;
    mag = (mag + ((ANG_W+1)'(1) << (ANG_K - 1))) >> ANG_K;
    rnd_ang = z[ANG_W-1] ? -$signed(OUT_W'(mag)) : $signed(OUT_W'(mag));
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sd_q[0] <= side_i;
      for (int k = 1; k < NST; k++) begin
        sd_q[k] <= sd_q[k-1];
      end
    end
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    logic signed [WW-1:0]    cx, cy, xp, yp;
    logic signed [ANG_W-1:0] zp;

    if (FRAC_BITS >= PROD_FRAC) begin : g_up
      assign cx = WW'(x_i[l]) <<< (FRAC_BITS - PROD_FRAC);
      assign cy = WW'(y_i[l]) <<< (FRAC_BITS - PROD_FRAC);
    end else begin : g_dn
      assign cx = rnd_work(x_i[l]);
      assign cy = rnd_work(y_i[l]);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x0_q[l] <= cx;
        y0_q[l] <= cy;
      end
    end

    always_comb begin
      xp = x0_q[l];
      yp = y0_q[l];
      zp = '0;
      if (x0_q[l][WW-1]) begin
        if (!y0_q[l][WW-1]) begin
          xp = y0_q[l];
          yp = -x0_q[l];
          zp = HALF_PI_ANG;
        end else begin
          xp = -y0_q[l];
          yp = x0_q[l];
          zp = -HALF_PI_ANG;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        xs_q[0][l] <= xp;
        ys_q[0][l] <= yp;
        zs_q[0][l] <= zp;
        zr_q[0][l] <= (x0_q[l] == '0) && (y0_q[l] == '0);
      end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
      logic signed [WW-1:0]    dx, dy, xn, yn;
      logic signed [ANG_W-1:0] zn;

      always_comb begin
        dx = ys_q[i][l] >>> i;
        dy = xs_q[i][l] >>> i;
        if (!ys_q[i][l][WW-1]) begin
          xn = xs_q[i][l] + dx;
          yn = ys_q[i][l] - dy;
          zn = zs_q[i][l] + ATAN_TAB[i];
        end else begin
          xn = xs_q[i][l] - dx;
          yn = ys_q[i][l] + dy;
          zn = zs_q[i][l] - ATAN_TAB[i];
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          xs_q[i+1][l] <= xn;
          ys_q[i+1][l] <= yn;
          zs_q[i+1][l] <= zn;
          zr_q[i+1][l] <= zr_q[i][l];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ang_q[l] <= zr_q[CORDIC_STAGES][l] ? '0 : rnd_ang(zs_q[CORDIC_STAGES][l]);
      end
    end

    assign ang_o[l] = ang_q[l];
  end

  assign valid_o = v_q[NST-1];
  assign side_o  = sd_q[NST-1];

endmodule

### hw/rtl/quaternion_to_euler_top.sv
// Throughput: one request per cycle while the output buffer is not full; the
// integer square root takes 29 pipeline stages and each CORDIC iteration one
// stage, all three angles in parallel lanes.
// A two-entry output buffer keeps the input ready while one result waits.
// Reset is asynchronous and active low; it clears all valid bits only.
module quaternion_to_euler_top import qte_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16,
  parameter int unsigned FRAC_BITS     = 14
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qte_in_if.sink     req_i,
  qte_out_if.source  res_o
);

  logic   en;
  logic   fr_valid;
  front_t fr_data;
  side_t  dl_q [ISQ_N];
  logic   sq_valid;
  logic [ISQ_N-1:0] sq_root;

  logic signed [PROD_W-1:0] cy [NUM_LANES];
  logic signed [PROD_W-1:0] cx [NUM_LANES];
  logic                     cd_valid;
  logic [1:0]               cd_side;
  logic signed [OUT_W-1:0]  cd_ang [NUM_LANES];
  logic signed [PITCH_W-1:0] pitch;

  logic                      out_valid_q, skid_valid_q;
  logic signed [OUT_W-1:0]   out_roll_q, out_yaw_q, skid_roll_q, skid_yaw_q;
  logic signed [PITCH_W-1:0] out_pitch_q, skid_pitch_q;

  assign en          = !skid_valid_q;
  assign req_i.ready = en;

  qte_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (req_i.valid),
    .quat_w_i (req_i.quat_w),
    .quat_x_i (req_i.quat_x),
    .quat_y_i (req_i.quat_y),
    .quat_z_i (req_i.quat_z),
    .valid_o  (fr_valid),
    .front_o  (fr_data)
  );

  qte_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .rad_i   (fr_data.rad),
    .valid_o (sq_valid),
    .root_o  (sq_root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_q[0] <= fr_data.side;
      for (int k = 1; k < ISQ_N; k++) begin
        dl_q[k] <= dl_q[k-1];
      end
    end
  end

  always_comb begin
    cy[LANE_ROLL]  = dl_q[ISQ_N-1].roll_y;
    cx[LANE_ROLL]  = dl_q[ISQ_N-1].roll_x;
    cy[LANE_PITCH] = dl_q[ISQ_N-1].s;
    cx[LANE_PITCH] = $signed(PROD_W'(sq_root));
    cy[LANE_YAW]   = dl_q[ISQ_N-1].yaw_y;
    cx[LANE_YAW]   = dl_q[ISQ_N-1].yaw_x;
  end

  qte_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES),
    .FRAC_BITS     (FRAC_BITS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .side_i  ({dl_q[ISQ_N-1].sat_pos, dl_q[ISQ_N-1].sat_neg}),
    .y_i     (cy),
    .x_i     (cx),
    .valid_o (cd_valid),
    .side_o  (cd_side),
    .ang_o   (cd_ang)
  );

  always_comb begin
    if (cd_side[1]) begin
      pitch = HALF_PI_OUT;
    end else if (cd_side[0]) begin
      pitch = -HALF_PI_OUT;
    end else begin
      pitch = cd_ang[LANE_PITCH][PITCH_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (en) begin
      if (cd_valid) begin
        if (out_valid_q && !res_o.ready) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end else if (res_o.ready) begin
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (cd_valid) begin
        if (out_valid_q && !res_o.ready) begin
          skid_roll_q  <= cd_ang[LANE_ROLL];
          skid_pitch_q <= pitch;
          skid_yaw_q   <= cd_ang[LANE_YAW];
        end else begin
          out_roll_q  <= cd_ang[LANE_ROLL];
          out_pitch_q <= pitch;
          out_yaw_q   <= cd_ang[LANE_YAW];
        end
      end
    end else if (res_o.ready) begin
      out_roll_q  <= skid_roll_q;
      out_pitch_q <= skid_pitch_q;
      out_yaw_q   <= skid_yaw_q;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.roll_angle  = out_roll_q;
  assign res_o.pitch_angle = out_pitch_q;
  assign res_o.yaw_angle   = out_yaw_q;

endmodule

### hw/rtl/qte_checker.sv
module qte_checker import qte_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic signed [OUT_W-1:0]   roll_i,
  input logic signed [PITCH_W-1:0] pitch_i,
  input logic signed [OUT_W-1:0]   yaw_i
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(roll_i) && $stable(pitch_i) && $stable(yaw_i))
    else $error("stalled result changed");

  // The input only stalls after a result was refused.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> $past(out_valid_i && !out_ready_i))
    else $error("input stalled without a refused result");

  // Draining the buffered result frees the input in the next cycle.
  a_stall_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i && out_ready_i |=> in_ready_i)
    else $error("input stall not released");

endmodule

bind quaternion_to_euler_top qte_checker u_qte_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (req_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .roll_i      (res_o.roll_angle),
  .pitch_i     (res_o.pitch_angle),
  .yaw_i       (res_o.yaw_angle)
);

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import qte_pkg::*;

  localparam int unsigned CORDIC_N   = 16;
  localparam int unsigned FRAC_N     = 14;
  localparam int unsigned LATENCY    = CORDIC_N + 36;
  localparam int unsigned CYCLE_CAP  = 400000;
  localparam longint      ONE_Q28    = 64'sd1 << PROD_FRAC;

  typedef struct packed {
    logic signed [OUT_W-1:0]   roll;
    logic signed [PITCH_W-1:0] pitch;
    logic signed [OUT_W-1:0]   yaw;
  } angles_t;

  logic clk_i;
  logic rst_ni;

  qte_in_if  req ();
  qte_out_if res ();

  quaternion_to_euler_top #(
    .CORDIC_STAGES(CORDIC_N),
    .FRAC_BITS    (FRAC_N)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .res_o (res)
  );

  angles_t pending_angles[$];
  int      mismatches = 0;
  int      cycles     = 0;
  bit      idle_en    = 1'b1;
  bit      hold_req   = 1'b0;
  int      hold_len   = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni     = 1'b0;
    req.valid  = 1'b0;
    req.quat_w = '0;
    req.quat_x = '0;
    req.quat_y = '0;
    req.quat_z = '0;
    res.ready  = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic longint round_half_away(longint v, int unsigned k);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (k - 1))) >>> k;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n    = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic longint cordic_angle(longint yv, longint xv);
    longint xa, ya, za, t, dx, dy;
    xa = round_half_away(xv, PROD_FRAC - FRAC_N);
    ya = round_half_away(yv, PROD_FRAC - FRAC_N);
    za = 0;
    if (xa == 0 && ya == 0) return 0;
    if (xa < 0) begin
      if (ya >= 0) begin
        t = xa; xa = ya; ya = -t; za = longint'(HALF_PI_ANG);
      end else begin
        t = xa; xa = -ya; ya = t; za = -longint'(HALF_PI_ANG);
      end
    end
    for (int i = 0; i < CORDIC_N && i < MAX_STAGES; i++) begin
      dx = ya >>> i;
      dy = xa >>> i;
      if (ya >= 0) begin
        xa = xa + dx; ya = ya - dy; za = za + longint'(ATAN_TAB[i]);
      end else begin
        xa = xa - dx; ya = ya + dy; za = za - longint'(ATAN_TAB[i]);
      end
    end
    return round_half_away(za, ANG_FRAC - OUT_FRAC);
  endfunction

  function automatic angles_t predict_angles(logic signed [15:0] qw, logic signed [15:0] qx,
                                             logic signed [15:0] qy, logic signed [15:0] qz);
    longint  w, x, y, z, s, c, p;
    angles_t a;
    w = qw; x = qx; y = qy; z = qz;
    a.roll = OUT_W'(cordic_angle(2 * (w * x + y * z), ONE_Q28 - 2 * (x * x + y * y)));
    a.yaw  = OUT_W'(cordic_angle(2 * (w * z + x * y), ONE_Q28 - 2 * (y * y + z * z)));
    s = 2 * (w * y - x * z);
    if (s >= ONE_Q28) begin
      p = longint'(HALF_PI_OUT);
    end else if (s <= -ONE_Q28) begin
      p = -longint'(HALF_PI_OUT);
    end else begin
      c = longint'(int_sqrt((64'd1 << (2 * PROD_FRAC)) - longint'(s * s)));
      p = cordic_angle(s, c);
    end
    a.pitch = PITCH_W'(p);
    return a;
  endfunction

  // Receiver: random stalls, plus long hold-offs on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        res.ready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
      end
      res.ready <= !(idle_en && $urandom_range(99) < 11);
    end
  end

  always @(posedge clk_i) begin
    angles_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (pending_angles.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        want = pending_angles.pop_front();
        if (res.roll_angle !== want.roll) begin
          $error("roll_angle: expected %0d, got %0d", want.roll, res.roll_angle);
          mismatches++;
        end
        if (res.pitch_angle !== want.pitch) begin
          $error("pitch_angle: expected %0d, got %0d", want.pitch, res.pitch_angle);
          mismatches++;
        end
        if (res.yaw_angle !== want.yaw) begin
          $error("yaw_angle: expected %0d, got %0d", want.yaw, res.yaw_angle);
          mismatches++;
        end
      end
    end
  end

  task automatic send_quat(input logic signed [15:0] qw, input logic signed [15:0] qx,
                           input logic signed [15:0] qy, input logic signed [15:0] qz);
    if (idle_en && $urandom_range(99) < 11) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req.valid  <= 1'b1;
    req.quat_w <= qw;
    req.quat_x <= qx;
    req.quat_y <= qy;
    req.quat_z <= qz;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    pending_angles.push_back(predict_angles(qw, qx, qy, qz));
  endtask

  task automatic drain;
    req.valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  task automatic send_unit_quat;
    real a, b, c, d, n;
    a = real'(int'($urandom_range(65535)) - 32768);
    b = real'(int'($urandom_range(65535)) - 32768);
    c = real'(int'($urandom_range(65535)) - 32768);
    d = real'(int'($urandom_range(65535)) - 32768);
    if ($urandom_range(9) == 0) begin
      c = a;
      b = b / 200.0;
      d = d / 200.0;
    end
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 1.0) n = 1.0;
    send_quat(16'($rtoi(a / n * 16384.0)), 16'($rtoi(b / n * 16384.0)),
              16'($rtoi(c / n * 16384.0)), 16'($rtoi(d / n * 16384.0)));
  endtask

  task automatic send_mixed(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 80) begin
        send_unit_quat();
      end else begin
        send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end
    end
  endtask

  task automatic test_directed;
    send_quat(16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 0, 0, 16384);
    send_quat(-16384, 0, 0, 0);
    send_quat(11585, 11585, 0, 0);
    send_quat(11585, 0, 0, -11585);
    send_quat(16384, 0, 8192, 0);
    send_quat(16384, 0, -8192, 0);
    send_quat(11586, 0, 11586, 0);
    send_quat(11586, 0, -11586, 0);
    send_quat(11585, 0, 11585, 0);
    send_quat(0, 8192, 8192, 0);
    send_quat(16384, 16384, 16384, 16384);
    send_quat(-16384, -16384, -16384, -16384);
    send_quat(-32768, -32768, -32768, -32768);
    send_quat(32767, 32767, 32767, 32767);
    send_quat(-32768, 32767, -32768, 32767);
    send_quat(0, 0, 0, 0);
    send_quat(8192, 8192, 8192, 8192);
    send_quat(8192, -8192, 8192, -8192);
    drain();
  endtask

  task automatic test_random;
    send_mixed(1200);
    drain();
  endtask

  task automatic test_no_idle;
    idle_en = 1'b0;
    send_mixed(300);
    drain();
    idle_en = 1'b1;
  endtask

  task automatic test_backpressure;
    hold_len = 300;
    hold_req = 1'b1;
    send_mixed(250);
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    test_no_idle();
    test_backpressure();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### quaternion_to_euler_top.f
hw/rtl/qte_pkg.sv
hw/rtl/qte_if.sv
hw/rtl/qte_front.sv
hw/rtl/qte_isqrt.sv
hw/rtl/qte_cordic.sv
hw/rtl/quaternion_to_euler_top.sv
hw/rtl/qte_checker.sv
tb/sv/testbench.sv
